// ===== rtl/core/rnnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnnc_pkg: shared definitions of the recurrent cell block
// Types, codes, default sizes and the tanh table used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rnnc_pkg;

	localparam int HIDDEN_DEF      = 128;
	localparam int VOCAB_MAX_DEF   = 64;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] SEL_INPUT  = 3'd0;
	localparam logic [2:0] SEL_RECUR  = 3'd1;
	localparam logic [2:0] SEL_OUTPUT = 3'd2;
	localparam logic [2:0] SEL_HBIAS  = 3'd3;
	localparam logic [2:0] SEL_OBIAS  = 3'd4;

	localparam logic [14:0] TANH_TAB [33] = '{
		15'd0,     15'd8026,  15'd15143, 15'd20813, 15'd24956, 15'd27797,
		15'd29660, 15'd30847, 15'd31589, 15'd32048, 15'd32329, 15'd32501,
		15'd32606, 15'd32670, 15'd32708, 15'd32732, 15'd32746, 15'd32755,
		15'd32760, 15'd32763, 15'd32765, 15'd32766, 15'd32767, 15'd32767,
		15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767,
		15'd32767, 15'd32767, 15'd32767
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HID,
		ST_HWAIT,
		ST_OUT,
		ST_OWAIT
	} state_t;

	typedef struct packed {
		logic rotate;
		logic push;
		logic load;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rnnc_cell.sv =====
// ----------------------------------------------------------------------------
// rnnc_cell: one link of the hidden state chain
// Holds one hidden value and one value of the new hidden vector.
// ----------------------------------------------------------------------------
`default_nettype none

module rnnc_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire rnnc_pkg::cell_ctl_t ctl,
	input  wire  signed [15:0]   h_nb,
	input  wire  signed [15:0]   s_nb,
	output logic signed [15:0]   h_q,
	output logic signed [15:0]   s_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (ctl.clear) begin
			h_q <= '0;
		end else if (ctl.load) begin
			h_q <= s_q;
		end else if (ctl.rotate) begin
			h_q <= h_nb;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			s_q <= s_nb;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rnnc_tanh.sv =====
// ----------------------------------------------------------------------------
// rnnc_tanh: table tanh
// Two-stage Q4.12 to Q1.15 tanh by linear interpolation of a 33-entry table.
// ----------------------------------------------------------------------------
`default_nettype none

module rnnc_tanh (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 x_vld,
	input  wire  signed [15:0]  x,
	output logic                y_vld_q,
	output logic signed [15:0]  y_q
);

	logic [16:0] xs;
	logic [16:0] mag;
	logic [6:0]  ti;
	logic [4:0]  idx;
	logic [9:0]  f;
	logic        sat;
	logic [14:0] t0;
	logic [14:0] t1;
	logic [14:0] d;
	logic [24:0] prod;

	logic        vld_s1;
	logic        neg_s1;
	logic [14:0] base_s1;
	logic [24:0] prod_s1;
	logic [15:0] y;
	logic [15:0] frac;

	always_comb begin
		xs   = {x[15], x};
		mag  = x[15] ? (~xs + 17'd1) : xs;
		ti   = mag[16:10];
		f    = mag[9:0];
		sat  = (ti >= 7'd32);
		idx  = ti[4:0];
		t0   = rnnc_pkg::TANH_TAB[idx];
		t1   = rnnc_pkg::TANH_TAB[6'(idx) + 6'd1];
		d    = t1 - t0;
		prod = 25'(d) * 25'(f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			y_vld_q <= 1'b0;
		end else begin
			vld_s1  <= x_vld;
			y_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= x[15];
		base_s1 <= sat ? rnnc_pkg::TANH_TAB[32] : t0;
		prod_s1 <= sat ? '0 : prod;
	end

	always_comb begin
		frac = 16'((prod_s1 + 25'd512) >> 10);
		y    = 16'(base_s1) + frac;
	end

	always_ff @(posedge clk) begin
		y_q <= neg_s1 ? signed'(~y + 16'd1) : signed'(y);
	end

endmodule

`default_nettype wire

// ===== rtl/core/rnn_cell_forward.sv =====
// ----------------------------------------------------------------------------
// rnn_cell_forward: Elman recurrent cell, forward step
// Weight store, one multiply-accumulate unit fed by a rotating chain of
// hidden state cells, table tanh, and a logit result port.
// ----------------------------------------------------------------------------
//
//  channel   ports                                    handshake
//  request   opcode matrix_select row_index col_index  start, busy
//            weight_value symbol
//  config    cfg_wdata                                cfg_we
//  result    logit_index logit_value last             logit_strobe
//
// A write or clear request is done while the block stays idle. A step request
// runs the hidden phase, waits for all tanh results, then runs the output phase;
// in both phases the single multiply-accumulate unit takes one product per cycle
// while the hidden chain rotates one place per cycle. Reset clears the hidden
// chain at once. The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rnn_cell_forward #(
	parameter int HIDDEN      = rnnc_pkg::HIDDEN_DEF,
	parameter int VOCAB_MAX   = rnnc_pkg::VOCAB_MAX_DEF,
	parameter int WEIGHT_BITS = rnnc_pkg::WEIGHT_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire  [1:0]          opcode,
	input  wire  [2:0]          matrix_select,
	input  wire  [6:0]          row_index,
	input  wire  [6:0]          col_index,
	input  wire  signed [15:0]  weight_value,
	input  wire  [5:0]          symbol,
	input  wire                 cfg_we,
	input  wire  [6:0]          cfg_wdata,
	output logic                logit_strobe,
	output logic [5:0]          logit_index,
	output logic signed [15:0]  logit_value,
	output logic                last
);

	localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int HW    = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
	localparam int VW    = $clog2(VOCAB_MAX);
	localparam int RMAX  = (HIDDEN > VOCAB_MAX) ? HIDDEN : VOCAB_MAX;
	localparam int RW    = $clog2(RMAX);
	localparam int PW    = $clog2(HIDDEN + 1);
	localparam int IA_W  = $clog2(HIDDEN * VOCAB_MAX);
	localparam int RA_W  = (HIDDEN > 1) ? $clog2(HIDDEN * HIDDEN) : 1;
	localparam int OA_W  = $clog2(VOCAB_MAX * HIDDEN);
	localparam int ACC_W = 32 + $clog2(HIDDEN + 1) + 2;

	localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(32768);

	rnnc_pkg::state_t    state_q, state_d;
	rnnc_pkg::cell_ctl_t ctl;

	logic [RW-1:0] row_q;
	logic [HW-1:0] col_q;
	logic [6:0]    nv_q;
	logic [6:0]    vocab_q;
	logic [5:0]    sym_q;
	logic          usein_q;
	logic [PW-1:0] pcnt_q;

	logic          col_last, row_last_h, row_last_o, iss, load_go, accept, wr;
	logic [6:0]    nv_eff;
	logic signed [WB-1:0] wword;

	logic signed [WB-1:0] mem_in  [HIDDEN*VOCAB_MAX];
	logic signed [WB-1:0] mem_rec [HIDDEN*HIDDEN];
	logic signed [WB-1:0] mem_out [VOCAB_MAX*HIDDEN];
	logic signed [WB-1:0] mem_hb  [HIDDEN];
	logic signed [WB-1:0] mem_ob  [VOCAB_MAX];

	logic signed [WB-1:0] iw_s1, rw_s1, ow_s1, hb_s1, ob_s1;
	logic signed [15:0]   h_s1;
	logic                 vld_s1, ph_s1, first_s1, lastc_s1;
	logic [RW-1:0]        row_s1;

	logic signed [31:0]   prod_s2;
	logic signed [16:0]   base_s2;
	logic                 vld_s2, ph_s2, first_s2, lastc_s2;
	logic [RW-1:0]        row_s2;

	logic signed [ACC_W-1:0] acc_s3;
	logic                    vld_s3, ph_s3, lastc_s3;
	logic [RW-1:0]           row_s3;

	logic signed [ACC_W-1:0] qsh;
	logic signed [15:0]      qv;
	logic                    q_vld_q;
	logic signed [15:0]      q12_q;
	logic                    t_vld;
	logic signed [15:0]      t_y;

	logic signed [15:0] h_w [HIDDEN];
	logic signed [15:0] s_w [HIDDEN];

	assign accept     = start && !busy;
	assign wr         = accept && (opcode == rnnc_pkg::OP_WRITE);
	assign col_last   = (int'(col_q) == HIDDEN - 1);
	assign row_last_h = (int'(row_q) == HIDDEN - 1);
	assign row_last_o = (int'(row_q) == int'(nv_q) - 1);
	assign wword      = WB'(weight_value);
	assign nv_eff     = (vocab_q == 7'd0) ? 7'd1 :
	                    ((int'(vocab_q) > VOCAB_MAX) ? 7'(VOCAB_MAX) : vocab_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= 7'd64;
		end else if (cfg_we) begin
			vocab_q <= cfg_wdata;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rnnc_pkg::ST_IDLE: begin
				if (accept && opcode == rnnc_pkg::OP_STEP) state_d = rnnc_pkg::ST_HID;
			end
			rnnc_pkg::ST_HID: begin
				if (col_last && row_last_h) state_d = rnnc_pkg::ST_HWAIT;
			end
			rnnc_pkg::ST_HWAIT: begin
				if (int'(pcnt_q) == HIDDEN) state_d = rnnc_pkg::ST_OUT;
			end
			rnnc_pkg::ST_OUT: begin
				if (col_last && row_last_o) state_d = rnnc_pkg::ST_OWAIT;
			end
			rnnc_pkg::ST_OWAIT: begin
				if (logit_strobe && last) state_d = rnnc_pkg::ST_IDLE;
			end
			default: state_d = rnnc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		iss     = 1'b0;
		load_go = 1'b0;
		busy    = 1'b1;
		case (state_q)
			rnnc_pkg::ST_IDLE:  busy = 1'b0;
			rnnc_pkg::ST_HID:   iss = 1'b1;
			rnnc_pkg::ST_HWAIT: load_go = (int'(pcnt_q) == HIDDEN);
			rnnc_pkg::ST_OUT:   iss = 1'b1;
			rnnc_pkg::ST_OWAIT: iss = 1'b0;
			default:            busy = 1'b1;
		endcase
		ctl.rotate = iss;
		ctl.push   = t_vld;
		ctl.load   = load_go;
		ctl.clear  = accept && (opcode == rnnc_pkg::OP_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rnnc_pkg::ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			nv_q    <= 7'd1;
			sym_q   <= '0;
			usein_q <= 1'b0;
			pcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept && opcode == rnnc_pkg::OP_STEP) begin
				row_q   <= '0;
				col_q   <= '0;
				nv_q    <= nv_eff;
				sym_q   <= symbol;
				usein_q <= (7'(symbol) < nv_eff);
			end else if (iss) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + HW'(1);
				end
			end else if (load_go) begin
				row_q <= '0;
				col_q <= '0;
			end
			if (load_go) begin
				pcnt_q <= '0;
			end else if (t_vld) begin
				pcnt_q <= pcnt_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && matrix_select == rnnc_pkg::SEL_INPUT && int'(row_index) < HIDDEN &&
		    int'(col_index) < VOCAB_MAX) begin
			mem_in[IA_W'(int'(row_index) * VOCAB_MAX + int'(col_index))] <= wword;
		end
		iw_s1 <= mem_in[IA_W'(int'(row_q) * VOCAB_MAX + int'(sym_q))];
	end

	always_ff @(posedge clk) begin
		if (wr && matrix_select == rnnc_pkg::SEL_RECUR && int'(row_index) < HIDDEN &&
		    int'(col_index) < HIDDEN) begin
			mem_rec[RA_W'(int'(row_index) * HIDDEN + int'(col_index))] <= wword;
		end
		rw_s1 <= mem_rec[RA_W'(int'(row_q) * HIDDEN + int'(col_q))];
	end

	always_ff @(posedge clk) begin
		if (wr && matrix_select == rnnc_pkg::SEL_OUTPUT && int'(row_index) < VOCAB_MAX &&
		    int'(col_index) < HIDDEN) begin
			mem_out[OA_W'(int'(row_index) * HIDDEN + int'(col_index))] <= wword;
		end
		ow_s1 <= mem_out[OA_W'(int'(VW'(row_q)) * HIDDEN + int'(col_q))];
	end

	always_ff @(posedge clk) begin
		if (wr && matrix_select == rnnc_pkg::SEL_HBIAS && int'(row_index) < HIDDEN) begin
			mem_hb[HW'(row_index)] <= wword;
		end
		hb_s1 <= mem_hb[HW'(row_q)];
	end

	always_ff @(posedge clk) begin
		if (wr && matrix_select == rnnc_pkg::SEL_OBIAS && int'(row_index) < VOCAB_MAX) begin
			mem_ob[VW'(row_index)] <= wword;
		end
		ob_s1 <= mem_ob[VW'(row_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			q_vld_q      <= 1'b0;
			logit_strobe <= 1'b0;
		end else begin
			vld_s1       <= iss;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			q_vld_q      <= vld_s3 && lastc_s3 && !ph_s3;
			logit_strobe <= vld_s3 && lastc_s3 && ph_s3;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1    <= (state_q == rnnc_pkg::ST_OUT);
		first_s1 <= (col_q == '0);
		lastc_s1 <= col_last;
		row_s1   <= row_q;
		h_s1     <= h_w[0];

		prod_s2  <= 32'(16'(ph_s1 ? ow_s1 : rw_s1)) * 32'(h_s1);
		base_s2  <= ph_s1 ? 17'(ob_s1) : (17'(hb_s1) + (usein_q ? 17'(iw_s1) : 17'sd0));
		ph_s2    <= ph_s1;
		first_s2 <= first_s1;
		lastc_s2 <= lastc_s1;
		row_s2   <= row_s1;

		acc_s3   <= (first_s2 ? (ACC_W'(base_s2) <<< 15) : acc_s3) + ACC_W'(prod_s2);
		ph_s3    <= ph_s2;
		lastc_s3 <= lastc_s2;
		row_s3   <= row_s2;
	end

	always_comb begin
		qsh = (acc_s3 + ACC_W'(16384)) >>> 15;
		if (qsh > Q_MAX) begin
			qv = 16'sd32767;
		end else if (qsh < Q_MIN) begin
			qv = -16'sd32768;
		end else begin
			qv = 16'(qsh);
		end
	end

	always_ff @(posedge clk) begin
		q12_q       <= qv;
		logit_value <= qv;
		logit_index <= 6'(row_s3);
		last        <= (int'(row_s3) == int'(nv_q) - 1);
	end

	rnnc_tanh u_tanh (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_vld   (q_vld_q),
		.x       (q12_q),
		.y_vld_q (t_vld),
		.y_q     (t_y)
	);

	for (genvar i = 0; i < HIDDEN; i++) begin : g_chain
		rnnc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.h_nb   (h_w[(i + 1) % HIDDEN]),
			.s_nb   ((i == HIDDEN - 1) ? t_y : s_w[(i + 1) % HIDDEN]),
			.h_q    (h_w[i]),
			.s_q    (s_w[i])
		);
	end

`ifndef SYNTH
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !logit_strobe)
		else $error("Result strobe while idle.");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		logit_strobe && last |=> !busy)
		else $error("Step did not end after its last logit.");

	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pcnt_q) <= HIDDEN)
		else $error("More hidden values than hidden cells.");

	a_no_push_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rnnc_pkg::ST_OUT) |-> !t_vld)
		else $error("Tanh result during the output phase.");
`endif

endmodule

`default_nettype wire
